/* src/ssp_pkg.sv */
package ssp_pkg;

    localparam int COORD_W          = 32;
    localparam int RADIUS_W         = 31;
    localparam int NORMAL_W         = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    // Differences of two coordinates and their products.
    localparam int DIFF_W   = COORD_W + 1;
    localparam int HALF_W   = DIFF_W;
    localparam int DEN_W    = 2 * DIFF_W;
    localparam int NUM_W    = DEN_W + 1;
    localparam int PROD_W   = DEN_W + DIFF_W;
    // The rounded offset along the segment never exceeds |V| + 1.
    localparam int OFS_QB   = DIFF_W + 1;
    localparam int OFFSET_W = OFS_QB + 2;
    localparam int SQ_W     = 2 * RADIUS_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = SUM_W / 2;

    localparam logic CMD_POINT   = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_z;
        logic [RADIUS_W-1:0]        sphere_radius;
        logic signed [COORD_W-1:0]  point_a_x;
        logic signed [COORD_W-1:0]  point_a_y;
        logic signed [COORD_W-1:0]  point_a_z;
        logic signed [COORD_W-1:0]  point_b_x;
        logic signed [COORD_W-1:0]  point_b_y;
        logic signed [COORD_W-1:0]  point_b_z;
    } t_req;

    typedef struct packed {
        logic                       hit;
        logic [RADIUS_W-1:0]        penetration;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
    } t_rsp;

endpackage

/* src/ssp_if.sv */
interface ssp_req_if;
    import ssp_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ssp_rsp_if;
    import ssp_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/sphere_segment_point_contact.sv */
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// The segment offset divider (34 stages), the square root (32 stages) and the
// normal dividers (P_NORMAL_FRAC_BITS + 1 stages) set the depth.
// Reset clears only the valid bits; the pipeline is empty afterwards.
module sphere_segment_point_contact #(
    parameter int P_NORMAL_FRAC_BITS = ssp_pkg::NORMAL_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssp_req_if.sink   i_req,
    ssp_rsp_if.source o_rsp
);
    import ssp_pkg::*;

    localparam int NQB    = P_NORMAL_FRAC_BITS + 1;
    localparam int NNUM_W = RADIUS_W + NQB;
    localparam int SIG_W  = NQB + 1;

    typedef struct packed {
        logic                          seg;
        logic                          smiss;
        logic [RADIUS_W-1:0]           radius;
        logic [2:0][DIFF_W-1:0]        n;
        logic [2:0]                    vneg;
    } t_side_ofs;

    typedef struct packed {
        logic                          miss;
        logic [2:0]                    neg;
        logic [2:0][RADIUS_W-1:0]      ad;
        logic [RADIUS_W-1:0]           radius;
    } t_side_root;

    typedef struct packed {
        logic                          miss;
        logic [2:0]                    neg;
        logic [RADIUS_W-1:0]           radius;
        logic [RADIUS_W-1:0]           mag;
    } t_side_norm;

    logic w_en;
    logic r_out_valid;
    t_rsp r_out;

    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    // Stage A: differences N = C - A and V = B - A.
    logic signed [COORD_W-1:0] c [3];
    logic signed [COORD_W-1:0] a [3];
    logic signed [COORD_W-1:0] b [3];

    always_comb begin
        c[0] = i_req.payload.center_x;
        c[1] = i_req.payload.center_y;
        c[2] = i_req.payload.center_z;
        a[0] = i_req.payload.point_a_x;
        a[1] = i_req.payload.point_a_y;
        a[2] = i_req.payload.point_a_z;
        b[0] = i_req.payload.point_b_x;
        b[1] = i_req.payload.point_b_y;
        b[2] = i_req.payload.point_b_z;
    end

    logic                     r_a_valid;
    logic                     r_a_cmd;
    logic [RADIUS_W-1:0]      r_a_r;
    logic signed [DIFF_W-1:0] r_a_n [3];
    logic signed [DIFF_W-1:0] r_a_v [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_cmd <= i_req.payload.command;
            r_a_r   <= i_req.payload.sphere_radius;
            for (int i = 0; i < 3; i++) begin
                r_a_n[i] <= DIFF_W'(c[i]) - DIFF_W'(a[i]);
                r_a_v[i] <= DIFF_W'(b[i]) - DIFF_W'(a[i]);
            end
        end
    end

    // Stage B: products V.V and N.V per axis.
    logic                     r_b_valid;
    logic                     r_b_cmd;
    logic [RADIUS_W-1:0]      r_b_r;
    logic signed [DIFF_W-1:0] r_b_n [3];
    logic signed [DIFF_W-1:0] r_b_v [3];
    logic signed [DEN_W-1:0]  r_b_vv [3];
    logic signed [DEN_W-1:0]  r_b_nv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_cmd <= r_a_cmd;
            r_b_r   <= r_a_r;
            for (int i = 0; i < 3; i++) begin
                r_b_n[i]  <= r_a_n[i];
                r_b_v[i]  <= r_a_v[i];
                r_b_vv[i] <= DEN_W'(r_a_v[i] * r_a_v[i]);
                r_b_nv[i] <= DEN_W'(r_a_n[i] * r_a_v[i]);
            end
        end
    end

    // Stage C: sums and the exact test of t against [0,1].
    logic [DEN_W-1:0]        n_c_den;
    logic signed [NUM_W-1:0] n_c_num;
    logic                    n_c_seg;
    logic                    n_c_smiss;

    always_comb begin
        n_c_den = DEN_W'(unsigned'(r_b_vv[0])) + DEN_W'(unsigned'(r_b_vv[1]))
                + DEN_W'(unsigned'(r_b_vv[2]));
        n_c_num = NUM_W'(r_b_nv[0]) + NUM_W'(r_b_nv[1]) + NUM_W'(r_b_nv[2]);
        // A zero-length segment falls back to the point test on A.
        n_c_seg   = (r_b_cmd == CMD_SEGMENT) && (n_c_den != '0);
        n_c_smiss = n_c_seg && (n_c_num[NUM_W-1] || ($signed({1'b0, n_c_den}) < n_c_num));
    end

    logic                     r_c_valid;
    logic                     r_c_seg;
    logic                     r_c_smiss;
    logic [RADIUS_W-1:0]      r_c_r;
    logic signed [DIFF_W-1:0] r_c_n [3];
    logic signed [DIFF_W-1:0] r_c_v [3];
    logic [DEN_W-1:0]         r_c_den;
    logic [DEN_W-1:0]         r_c_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_seg   <= n_c_seg;
            r_c_smiss <= n_c_smiss;
            r_c_r     <= r_b_r;
            r_c_den   <= n_c_den;
            r_c_num   <= DEN_W'(n_c_num);
            for (int i = 0; i < 3; i++) begin
                r_c_n[i] <= r_b_n[i];
                r_c_v[i] <= r_b_v[i];
            end
        end
    end

    // Stage D: num * |V_i| as two partial products.
    logic [DIFF_W-1:0] av [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            av[i] = r_c_v[i][DIFF_W-1] ? DIFF_W'(-r_c_v[i]) : DIFF_W'(r_c_v[i]);
        end
    end

    logic [DEN_W-1:0] r_d_lo [3];
    logic [DEN_W-1:0] r_d_hi [3];
    logic [DEN_W-1:0] r_d_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_den <= r_c_den;
            for (int i = 0; i < 3; i++) begin
                r_d_lo[i] <= DEN_W'(r_c_num[HALF_W-1:0] * av[i]);
                r_d_hi[i] <= DEN_W'(r_c_num[DEN_W-1:HALF_W] * av[i]);
            end
        end
    end

    // Stage E: full product plus half the divisor for rounding.
    logic [PROD_W-1:0] r_e_p [3];
    logic [DEN_W-1:0]  r_e_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_den <= r_d_den;
            for (int i = 0; i < 3; i++) begin
                r_e_p[i] <= PROD_W'(r_d_lo[i]) + (PROD_W'(r_d_hi[i]) << HALF_W)
                          + PROD_W'(r_d_den >> 1);
            end
        end
    end

    logic [OFS_QB-1:0] ofs_q [3];

    for (genvar i = 0; i < 3; i++) begin : g_ofs_div
        ssp_div #(
            .P_NUM_W (PROD_W),
            .P_DEN_W (DEN_W),
            .P_QB    (OFS_QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_e_p[i]),
            .i_den (r_e_den),
            .o_quo (ofs_q[i])
        );
    end

    t_side_ofs side_ofs_in;
    t_side_ofs side_ofs;
    logic      side_ofs_valid;

    always_comb begin
        side_ofs_in.seg    = r_c_seg;
        side_ofs_in.smiss  = r_c_smiss;
        side_ofs_in.radius = r_c_r;
        for (int i = 0; i < 3; i++) begin
            side_ofs_in.n[i]    = r_c_n[i];
            side_ofs_in.vneg[i] = r_c_v[i][DIFF_W-1];
        end
    end

    ssp_delay #(
        .T       (t_side_ofs),
        .P_DEPTH (OFS_QB + 2)
    ) u_dly_ofs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_valid),
        .i_data  (side_ofs_in),
        .o_valid (side_ofs_valid),
        .o_data  (side_ofs)
    );

    // Stage F: offset from the closest point to the centre.
    logic signed [OFFSET_W-1:0] n_f_d [3];

    always_comb begin
        logic signed [OFFSET_W-1:0] sn;
        logic signed [OFFSET_W-1:0] sq;
        for (int i = 0; i < 3; i++) begin
            sn = OFFSET_W'($signed(side_ofs.n[i]));
            sq = $signed(OFFSET_W'(ofs_q[i]));
            if (!side_ofs.seg) begin
                n_f_d[i] = sn;
            end else if (side_ofs.vneg[i]) begin
                n_f_d[i] = sn + sq;
            end else begin
                n_f_d[i] = sn - sq;
            end
        end
    end

    logic                       r_f_valid;
    logic                       r_f_miss;
    logic [RADIUS_W-1:0]        r_f_r;
    logic signed [OFFSET_W-1:0] r_f_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= side_ofs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_miss <= side_ofs.smiss;
            r_f_r    <= side_ofs.radius;
            for (int i = 0; i < 3; i++) r_f_d[i] <= n_f_d[i];
        end
    end

    // Stage G: magnitudes, squares and r*r.
    logic [OFFSET_W-1:0] ad [3];
    logic                n_g_far;

    always_comb begin
        n_g_far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ad[i] = r_f_d[i][OFFSET_W-1] ? OFFSET_W'(-r_f_d[i]) : OFFSET_W'(r_f_d[i]);
            // A component of 2^31 or more already puts the point outside any radius.
            n_g_far = n_g_far || (ad[i][OFFSET_W-1:RADIUS_W] != '0);
        end
    end

    logic                r_g_valid;
    logic                r_g_miss;
    logic [RADIUS_W-1:0] r_g_r;
    logic [SQ_W-1:0]     r_g_rr;
    logic [2:0]          r_g_neg;
    logic [RADIUS_W-1:0] r_g_ad [3];
    logic [SQ_W-1:0]     r_g_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_miss <= r_f_miss || n_g_far;
            r_g_r    <= r_f_r;
            r_g_rr   <= SQ_W'(r_f_r * r_f_r);
            for (int i = 0; i < 3; i++) begin
                r_g_neg[i] <= r_f_d[i][OFFSET_W-1];
                r_g_ad[i]  <= ad[i][RADIUS_W-1:0];
                r_g_sq[i]  <= SQ_W'(ad[i][RADIUS_W-1:0] * ad[i][RADIUS_W-1:0]);
            end
        end
    end

    // Stage H: squared distance and radius compare.
    logic [SUM_W-1:0] n_h_sum;

    assign n_h_sum = SUM_W'(r_g_sq[0]) + SUM_W'(r_g_sq[1]) + SUM_W'(r_g_sq[2]);

    logic             r_h_valid;
    logic [SUM_W-1:0] r_h_sum;
    t_side_root       r_h_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_en) begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_sum         <= n_h_sum;
            r_h_side.miss   <= r_g_miss || (n_h_sum > SUM_W'(r_g_rr));
            r_h_side.neg    <= r_g_neg;
            r_h_side.radius <= r_g_r;
            for (int i = 0; i < 3; i++) r_h_side.ad[i] <= r_g_ad[i];
        end
    end

    logic [ROOT_W-1:0] root;

    ssp_isqrt #(
        .P_ROOT_W (ROOT_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_h_sum),
        .o_root (root)
    );

    t_side_root side_root;
    logic       side_root_valid;

    ssp_delay #(
        .T       (t_side_root),
        .P_DEPTH (ROOT_W)
    ) u_dly_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_valid),
        .i_data  (r_h_side),
        .o_valid (side_root_valid),
        .o_data  (side_root)
    );

    // Stage I: normal numerators with half the distance for rounding.
    // On a hit the distance never exceeds the radius, so it fits the radius width.
    logic [RADIUS_W-1:0] mag;

    assign mag = root[RADIUS_W-1:0];

    logic              r_i_valid;
    t_side_norm        r_i_side;
    logic [NNUM_W-1:0] r_i_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (w_en) begin
            r_i_valid <= side_root_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_side.miss   <= side_root.miss;
            r_i_side.neg    <= side_root.neg;
            r_i_side.radius <= side_root.radius;
            r_i_side.mag    <= mag;
            for (int i = 0; i < 3; i++) begin
                r_i_num[i] <= (NNUM_W'(side_root.ad[i]) << P_NORMAL_FRAC_BITS)
                            + NNUM_W'(mag >> 1);
            end
        end
    end

    logic [NQB-1:0] nrm_q [3];

    for (genvar i = 0; i < 3; i++) begin : g_nrm_div
        ssp_div #(
            .P_NUM_W (NNUM_W),
            .P_DEN_W (RADIUS_W),
            .P_QB    (NQB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_i_num[i]),
            .i_den (r_i_side.mag),
            .o_quo (nrm_q[i])
        );
    end

    t_side_norm side_norm;
    logic       side_norm_valid;

    ssp_delay #(
        .T       (t_side_norm),
        .P_DEPTH (NQB)
    ) u_dly_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_i_valid),
        .i_data  (r_i_side),
        .o_valid (side_norm_valid),
        .o_data  (side_norm)
    );

    // Stage J: result register.
    t_rsp n_out;

    always_comb begin
        logic signed [SIG_W-1:0]    sv [3];
        logic signed [NORMAL_W-1:0] nv [3];
        for (int i = 0; i < 3; i++) begin
            sv[i] = side_norm.neg[i] ? -$signed(SIG_W'(nrm_q[i])) : $signed(SIG_W'(nrm_q[i]));
            nv[i] = NORMAL_W'(sv[i]);
        end
        n_out = '0;
        if (!side_norm.miss) begin
            n_out.hit         = 1'b1;
            n_out.penetration = side_norm.radius - side_norm.mag;
            if (side_norm.mag == '0) begin
                // Centre on the contact point: the normal points along +y.
                n_out.normal_y = NORMAL_W'(SIG_W'(1) << P_NORMAL_FRAC_BITS);
            end else begin
                n_out.normal_x = nv[0];
                n_out.normal_y = nv[1];
                n_out.normal_z = nv[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= side_norm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
endmodule

/* src/ssp_delay.sv */
module ssp_delay #(
    parameter type T       = logic,
    parameter int  P_DEPTH = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  T     i_data,
    output logic o_valid,
    output T     o_data
);
    logic r_valid [P_DEPTH];
    T     r_data  [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < P_DEPTH; s++) r_valid[s] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < P_DEPTH; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int s = 1; s < P_DEPTH; s++) r_data[s] <= r_data[s-1];
        end
    end

    assign o_valid = r_valid[P_DEPTH-1];
    assign o_data  = r_data[P_DEPTH-1];
endmodule

/* src/ssp_div.sv */
// Restoring divider, one quotient bit per stage. The caller guarantees that
// the quotient fits in P_QB bits.
module ssp_div #(
    parameter int P_NUM_W = 8,
    parameter int P_DEN_W = 4,
    parameter int P_QB    = 4
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [P_NUM_W-1:0] i_num,
    input  logic [P_DEN_W-1:0] i_den,
    output logic [P_QB-1:0]    o_quo
);
    logic [P_DEN_W-1:0] r_rem [P_QB];
    logic [P_QB-1:0]    r_low [P_QB];
    logic [P_QB-1:0]    r_quo [P_QB];
    logic [P_DEN_W-1:0] r_den [P_QB];

    for (genvar s = 0; s < P_QB; s++) begin : g_step
        logic [P_DEN_W-1:0] rem_in;
        logic [P_DEN_W-1:0] den_in;
        logic [P_QB-1:0]    low_in;
        logic [P_QB-1:0]    quo_in;
        logic [P_DEN_W:0]   trial;
        logic               take;

        if (s == 0) begin : g_first
            assign rem_in = P_DEN_W'(i_num >> P_QB);
            assign low_in = i_num[P_QB-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin
            trial = {rem_in, low_in[P_QB-1]};
            take  = trial >= {1'b0, den_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? P_DEN_W'(trial - {1'b0, den_in}) : P_DEN_W'(trial);
                r_low[s] <= low_in << 1;
                r_quo[s] <= P_QB'({quo_in, take});
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[P_QB-1];
endmodule

/* src/ssp_isqrt.sv */
// Digit-by-digit integer square root, one root bit per stage.
module ssp_isqrt #(
    parameter int P_ROOT_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*P_ROOT_W-1:0] i_rad,
    output logic [P_ROOT_W-1:0]   o_root
);
    localparam int RAD_W = 2 * P_ROOT_W;
    localparam int REM_W = P_ROOT_W + 2;
    localparam int TRY_W = P_ROOT_W + 4;

    logic [REM_W-1:0]    r_rem  [P_ROOT_W];
    logic [RAD_W-1:0]    r_rad  [P_ROOT_W];
    logic [P_ROOT_W-1:0] r_root [P_ROOT_W];

    for (genvar s = 0; s < P_ROOT_W; s++) begin : g_step
        logic [REM_W-1:0]    rem_in;
        logic [RAD_W-1:0]    rad_in;
        logic [P_ROOT_W-1:0] root_in;
        logic [TRY_W-1:0]    trial;
        logic [TRY_W-1:0]    test;
        logic                take;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign rad_in  = r_rad[s-1];
            assign root_in = r_root[s-1];
        end

        always_comb begin
            trial = {rem_in, rad_in[RAD_W-1 -: 2]};
            test  = TRY_W'({root_in, 2'b01});
            take  = trial >= test;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? REM_W'(trial - test) : REM_W'(trial);
                r_rad[s]  <= rad_in << 2;
                r_root[s] <= P_ROOT_W'({root_in, take});
            end
        end
    end

    assign o_root = r_root[P_ROOT_W-1];
endmodule
